FILE: src/csp_pkg.sv
package csp_pkg;

    // Number of camera inputs with their own slicing threshold
    localparam int NUM_INPUTS = 2;
    localparam int ACT_W      = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

    // Short queue between classifier and sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Tick windows at 170 MHz, all bounds exclusive
    localparam logic [15:0] FULL_LO  = 16'd10030;
    localparam logic [15:0] FULL_HI  = 16'd11475;
    localparam logic [15:0] HALF_LO  = 16'd4930;
    localparam logic [15:0] HALF_HI  = 16'd6035;
    localparam logic [15:0] BROAD_LO = 16'd9520;
    localparam logic [15:0] BROAD_HI = 16'd9860;
    localparam logic [15:0] EDGE_LO  = 16'd1105;
    localparam logic [15:0] EDGE_HI  = 16'd1275;

    localparam logic [7:0]  HALF_SAT        = 8'd255;
    localparam logic [7:0]  HALF_FIELD_MIN  = 8'd4;
    localparam logic [7:0]  HALF_FLOOR      = 8'd5;
    localparam logic [7:0]  HALF_BLACK      = 8'd11;
    localparam logic [8:0]  LINE_CAP        = 9'd511;

    localparam logic [11:0] THR_RESET       = 12'd310;
    localparam logic [11:0] AMP_MIN_RESET   = 12'd124;
    localparam logic [11:0] AMP_MAX_RESET   = 12'd745;
    localparam logic [11:0] THR_MIN_RESET   = 12'd31;
    localparam logic [11:0] THR_MAX_RESET   = 12'd993;
    localparam logic [8:0]  MAX_LINE_RESET  = 9'd305;
    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(1);

    // Configuration register indexes
    localparam logic [2:0] REG_AMP_MIN  = 3'd0;
    localparam logic [2:0] REG_AMP_MAX  = 3'd1;
    localparam logic [2:0] REG_THR_MIN  = 3'd2;
    localparam logic [2:0] REG_THR_MAX  = 3'd3;
    localparam logic [2:0] REG_MAX_LINE = 3'd4;

    typedef enum logic [0:0] {
        OP_CAPTURE = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CLS_FULL  = 3'd0,
        CLS_HALF  = 3'd1,
        CLS_BROAD = 3'd2,
        CLS_EDGE  = 3'd3,
        CLS_OTHER = 3'd4,
        CLS_NONE  = 3'd5
    } pulse_class_t;

    // Classified request passed from front to back
    typedef struct packed {
        op_t          op;
        pulse_class_t cls;
        logic         adc_valid;
        logic [11:0]  adc_sample;
        logic         input_sel;
    } csp_req_t;

    // One result
    typedef struct packed {
        pulse_class_t pulse_class;
        logic         line_strobe;
        logic [8:0]   line_number;
        logic         field_start;
        logic         locked;
        logic         field_active;
        logic         sample_at_sync;
        logic [11:0]  threshold;
        logic         threshold_updated;
    } csp_res_t;

endpackage

FILE: src/composite_sync_pulse_parser_core.sv
// Path: an accepted request is loaded into the front register, then written
//   to the queue, then popped into the result register that drives m_valid.
// Throughput: one request per cycle while m_ready keeps the result register draining.
// Reset: synchronous, aresetn low; clears the queue, the tracking state, thresholds
//   to 310 per input, and the configuration registers to their defaults.
module composite_sync_pulse_parser_core (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_interval_ticks,
    input  logic        s_adc_valid,
    input  logic [11:0] s_adc_sample,
    input  logic        s_input_sel,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_pulse_class,
    output logic        m_line_strobe,
    output logic [8:0]  m_line_number,
    output logic        m_field_start,
    output logic        m_locked,
    output logic        m_field_active,
    output logic        m_sample_at_sync,
    output logic [11:0] m_threshold,
    output logic        m_threshold_updated
);

    // Front end: registers each request and sorts the interval into its tick
    // window. Classification needs no tracking state, so it runs ahead of tracking until the queue fills.
    logic               push;
    logic               queue_full;
    csp_pkg::csp_req_t  push_req;

    // Back end: field/line tracking and threshold filter, one request a cycle unless the result is stalled.
    logic               q_pop;
    logic               q_not_empty;
    csp_pkg::csp_req_t  q_head;
    csp_pkg::csp_res_t  res;

    csp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_interval_ticks (s_interval_ticks),
        .s_adc_valid      (s_adc_valid),
        .s_adc_sample     (s_adc_sample),
        .s_input_sel      (s_input_sel),
        .push             (push),
        .push_req         (push_req),
        .queue_full       (queue_full)
    );

    // Short queue decouples classification from tracking so either side can
    // stall without starving the other.
    csp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_req  (push_req),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The result register sits inside the back end; it pops the queue whenever
    // the register is empty or being drained that same cycle.
    csp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res       (res)
    );

    assign m_pulse_class       = res.pulse_class;
    assign m_line_strobe       = res.line_strobe;
    assign m_line_number       = res.line_number;
    assign m_field_start       = res.field_start;
    assign m_locked            = res.locked;
    assign m_field_active      = res.field_active;
    assign m_sample_at_sync    = res.sample_at_sync;
    assign m_threshold         = res.threshold;
    assign m_threshold_updated = res.threshold_updated;

endmodule

FILE: src/csp_front.sv
module csp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [15:0]        s_interval_ticks,
    input  logic               s_adc_valid,
    input  logic [11:0]        s_adc_sample,
    input  logic               s_input_sel,
    output logic               push,
    output csp_pkg::csp_req_t  push_req,
    input  logic               queue_full
);

    logic                      valid_reg;
    csp_pkg::csp_req_t         req_reg;
    csp_pkg::pulse_class_t     cls;

    // window check in fixed priority order
    always_comb begin
        priority if (s_interval_ticks > csp_pkg::FULL_LO && s_interval_ticks < csp_pkg::FULL_HI)
            cls = csp_pkg::CLS_FULL;
        else if (s_interval_ticks > csp_pkg::HALF_LO && s_interval_ticks < csp_pkg::HALF_HI)
            cls = csp_pkg::CLS_HALF;
        else if (s_interval_ticks > csp_pkg::BROAD_LO && s_interval_ticks < csp_pkg::BROAD_HI)
            cls = csp_pkg::CLS_BROAD;
        else if (s_interval_ticks > csp_pkg::EDGE_LO && s_interval_ticks < csp_pkg::EDGE_HI)
            cls = csp_pkg::CLS_EDGE;
        else
            cls = csp_pkg::CLS_OTHER;
    end

    assign push     = valid_reg && !queue_full;
    assign push_req = req_reg;
    assign s_ready  = !valid_reg || !queue_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.op         <= csp_pkg::op_t'(s_op);
            req_reg.cls        <= cls;
            req_reg.adc_valid  <= s_adc_valid;
            req_reg.adc_sample <= s_adc_sample;
            req_reg.input_sel  <= s_input_sel;
        end
    end

endmodule

FILE: src/csp_queue.sv
module csp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  csp_pkg::csp_req_t  push_req,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output csp_pkg::csp_req_t  head
);

    csp_pkg::csp_req_t                 mem [csp_pkg::QUEUE_DEPTH];
    logic [csp_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [csp_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [csp_pkg::QCNT_W-1:0]        count_reg;

    assign full      = (count_reg == csp_pkg::QCNT_W'(csp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    function automatic logic [csp_pkg::QPTR_W-1:0] ptr_inc(input logic [csp_pkg::QPTR_W-1:0] p);
        ptr_inc = (p == csp_pkg::QPTR_W'(csp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: src/csp_back.sv
module csp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [11:0]        cfg_wdata,
    input  logic               q_not_empty,
    input  csp_pkg::csp_req_t  q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output csp_pkg::csp_res_t  m_res
);

    // configuration
    logic [11:0] amp_min_reg, amp_max_reg, thr_min_reg, thr_max_reg;
    logic [8:0]  max_line_reg;

    // tracking state
    logic [7:0]                  half_count_reg,  half_count_next;
    logic [8:0]                  line_count_reg,  line_count_next;
    logic                        field_synced_reg, field_synced_next;
    logic                        lock_reg,        lock_next;
    logic                        discard_reg,     discard_next;
    logic                        floor_valid_reg, floor_valid_next;
    logic                        floor_pend_reg,  floor_pend_next;
    logic [11:0]                 floor_value_reg, floor_value_next;
    logic [csp_pkg::ACT_W-1:0]   active_reg,      active_next;
    logic                        field_flag_reg,  field_flag_next;
    logic                        sync_point_reg,  sync_point_next;
    logic [11:0]                 thr_reg  [csp_pkg::NUM_INPUTS];
    logic [11:0]                 thr_next [csp_pkg::NUM_INPUTS];

    logic                        m_valid_reg;
    csp_pkg::csp_res_t           res_reg, res_next;

    logic [csp_pkg::ACT_W-1:0]   idx_old, idx_new, sel_ext;
    logic [11:0]                 amp, mid, thr_upd;
    logic [13:0]                 acc;
    logic                        sample_ok;
    logic [9:0]                  line_inc;

    function automatic logic [csp_pkg::ACT_W-1:0] clamp_idx(input logic [csp_pkg::ACT_W-1:0] a);
        clamp_idx = ({1'b0, a} < (csp_pkg::ACT_W + 1)'(csp_pkg::NUM_INPUTS)) ?
                    a : csp_pkg::ACT_W'(csp_pkg::NUM_INPUTS - 1);
    endfunction

    assign q_pop   = q_not_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    // threshold update datapath: floor in floor_value_reg, black in the sample
    assign idx_old  = clamp_idx(active_reg);
    assign amp      = q_head.adc_sample - floor_value_reg;
    assign mid      = floor_value_reg + {1'b0, amp[11:1]};
    assign sample_ok = (q_head.adc_sample > floor_value_reg)
                    && (amp >= amp_min_reg) && (amp <= amp_max_reg)
                    && (mid >= thr_min_reg) && (mid <= thr_max_reg);
    assign acc      = {2'b00, thr_reg[idx_old]} + {1'b0, thr_reg[idx_old], 1'b0}
                    + {2'b00, mid} + 14'd2;
    assign thr_upd  = acc[13:2];
    assign sel_ext  = csp_pkg::ACT_W'(q_head.input_sel);

    always_comb begin
        half_count_next   = half_count_reg;
        line_count_next   = line_count_reg;
        field_synced_next = field_synced_reg;
        lock_next         = lock_reg;
        discard_next      = discard_reg;
        floor_valid_next  = floor_valid_reg;
        floor_pend_next   = floor_pend_reg;
        floor_value_next  = floor_value_reg;
        active_next       = active_reg;
        field_flag_next   = field_flag_reg;
        sync_point_next   = sync_point_reg;
        for (int i = 0; i < csp_pkg::NUM_INPUTS; i++) thr_next[i] = thr_reg[i];
        line_inc = '0;

        res_next = '0;
        res_next.pulse_class = csp_pkg::CLS_NONE;

        if (q_head.op == csp_pkg::OP_RESTART) begin
            if ({1'b0, sel_ext} < (csp_pkg::ACT_W + 1)'(csp_pkg::NUM_INPUTS)) begin
                active_next       = sel_ext;
                line_count_next   = '0;
                field_synced_next = 1'b0;
                half_count_next   = '0;
                floor_valid_next  = 1'b0;
                floor_pend_next   = 1'b0;
                sync_point_next   = 1'b0;
                discard_next      = 1'b1;
                field_flag_next   = 1'b0;
                lock_next         = 1'b0;
            end
        end else if (discard_reg) begin
            discard_next = 1'b0;
        end else begin
            res_next.pulse_class = q_head.cls;
            unique case (q_head.cls)
                csp_pkg::CLS_FULL: begin
                    if (half_count_reg >= csp_pkg::HALF_FIELD_MIN) begin
                        line_count_next   = '0;
                        field_synced_next = 1'b1;
                        lock_next         = 1'b1;
                        res_next.field_start = 1'b1;
                    end
                    half_count_next  = '0;
                    floor_valid_next = 1'b0;
                    floor_pend_next  = 1'b0;
                    sync_point_next  = 1'b0;
                    if (field_synced_next && line_count_next <= max_line_reg) begin
                        if (line_count_next != csp_pkg::LINE_CAP)
                            line_count_next = line_count_next + 1'b1;
                        line_inc = {1'b0, line_count_next};
                        res_next.line_strobe = (line_inc <= {1'b0, max_line_reg});
                        field_flag_next = 1'b1;
                    end
                end
                csp_pkg::CLS_HALF: begin
                    if (half_count_reg != csp_pkg::HALF_SAT)
                        half_count_next = half_count_reg + 1'b1;
                    if (half_count_next == csp_pkg::HALF_FLOOR && floor_pend_reg) begin
                        floor_valid_next = q_head.adc_valid;
                        if (q_head.adc_valid) floor_value_next = q_head.adc_sample;
                        sync_point_next = 1'b0;
                        floor_pend_next = 1'b0;
                    end
                    if (half_count_next == csp_pkg::HALF_BLACK && floor_valid_reg) begin
                        if (q_head.adc_valid && sample_ok) begin
                            thr_next[idx_old] = thr_upd;
                            res_next.threshold_updated = 1'b1;
                        end
                        floor_valid_next = 1'b0;
                    end
                    field_flag_next = 1'b0;
                end
                csp_pkg::CLS_BROAD: begin
                    if (half_count_reg >= csp_pkg::HALF_FIELD_MIN) begin
                        half_count_next  = csp_pkg::HALF_FIELD_MIN;
                        floor_valid_next = 1'b0;
                        floor_pend_next  = 1'b1;
                        sync_point_next  = 1'b1;
                    end
                end
                csp_pkg::CLS_EDGE: begin
                end
                default: begin
                    half_count_next  = '0;
                    floor_valid_next = 1'b0;
                    floor_pend_next  = 1'b0;
                    sync_point_next  = 1'b0;
                end
            endcase
        end

        idx_new = clamp_idx(active_next);
        res_next.line_number    = line_count_next;
        res_next.locked         = lock_next;
        res_next.field_active   = field_flag_next;
        res_next.sample_at_sync = sync_point_next;
        res_next.threshold      = thr_next[idx_new];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_min_reg  <= csp_pkg::AMP_MIN_RESET;
            amp_max_reg  <= csp_pkg::AMP_MAX_RESET;
            thr_min_reg  <= csp_pkg::THR_MIN_RESET;
            thr_max_reg  <= csp_pkg::THR_MAX_RESET;
            max_line_reg <= csp_pkg::MAX_LINE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                csp_pkg::REG_AMP_MIN:  amp_min_reg  <= cfg_wdata;
                csp_pkg::REG_AMP_MAX:  amp_max_reg  <= cfg_wdata;
                csp_pkg::REG_THR_MIN:  thr_min_reg  <= cfg_wdata;
                csp_pkg::REG_THR_MAX:  thr_max_reg  <= cfg_wdata;
                csp_pkg::REG_MAX_LINE: max_line_reg <= cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_count_reg   <= '0;
            line_count_reg   <= '0;
            field_synced_reg <= 1'b0;
            lock_reg         <= 1'b0;
            discard_reg      <= 1'b1;
            floor_valid_reg  <= 1'b0;
            floor_pend_reg   <= 1'b0;
            floor_value_reg  <= '0;
            active_reg       <= csp_pkg::ACTIVE_RESET;
            field_flag_reg   <= 1'b0;
            sync_point_reg   <= 1'b0;
            for (int i = 0; i < csp_pkg::NUM_INPUTS; i++) thr_reg[i] <= csp_pkg::THR_RESET;
        end else if (q_pop) begin
            half_count_reg   <= half_count_next;
            line_count_reg   <= line_count_next;
            field_synced_reg <= field_synced_next;
            lock_reg         <= lock_next;
            discard_reg      <= discard_next;
            floor_valid_reg  <= floor_valid_next;
            floor_pend_reg   <= floor_pend_next;
            floor_value_reg  <= floor_value_next;
            active_reg       <= active_next;
            field_flag_reg   <= field_flag_next;
            sync_point_reg   <= sync_point_next;
            for (int i = 0; i < csp_pkg::NUM_INPUTS; i++) thr_reg[i] <= thr_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: src/csp_checker.sv
module csp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_pulse_class,
    input  logic        m_line_strobe,
    input  logic [8:0]  m_line_number,
    input  logic        m_field_start,
    input  logic        m_locked,
    input  logic        m_threshold_updated
);

    // stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pulse_class) && $stable(m_line_number))
        else $error("result changed while stalled");

    // a field start is a full line that locks and carries line number one
    a_field_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_field_start |-> m_locked && m_line_number == 9'd1
            && m_pulse_class == csp_pkg::CLS_FULL)
        else $error("field start inconsistent");

    // line render only from a full line while locked
    a_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_strobe |-> m_locked && m_pulse_class == csp_pkg::CLS_FULL
            && m_line_number != 9'd0)
        else $error("line strobe without locked full line");

    // threshold only moves on a half line
    a_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_threshold_updated |-> m_pulse_class == csp_pkg::CLS_HALF)
        else $error("threshold update outside half line");

endmodule

bind composite_sync_pulse_parser_core csp_checker u_csp_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_pulse_class       (m_pulse_class),
    .m_line_strobe       (m_line_strobe),
    .m_line_number       (m_line_number),
    .m_field_start       (m_field_start),
    .m_locked            (m_locked),
    .m_threshold_updated (m_threshold_updated)
);

FILE: sim/csp_line_checker.sv
`timescale 1ns / 1ps

module csp_line_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_interval_ticks,
    input  logic        s_adc_valid,
    input  logic [11:0] s_adc_sample,
    input  logic        s_input_sel,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_pulse_class,
    input  logic        m_line_strobe,
    input  logic [8:0]  m_line_number,
    input  logic        m_field_start,
    input  logic        m_locked,
    input  logic        m_field_active,
    input  logic        m_sample_at_sync,
    input  logic [11:0] m_threshold,
    input  logic        m_threshold_updated,
    output int          bad_results,
    output int          results_owed
);

    logic [11:0] amp_lo, amp_hi, mid_lo, mid_hi;
    logic [8:0]  last_line;

    logic [7:0]  halves;
    logic [8:0]  line_cnt;
    logic [11:0] floor_code;
    logic [11:0] slice_thr [csp_pkg::NUM_INPUTS];
    int          act_in;
    bit          synced, lock_q, discard_q, floor_ok, floor_wait, field_q, at_sync;

    csp_pkg::csp_res_t line_results [$];

    function automatic int thr_slot();
        return (act_in < csp_pkg::NUM_INPUTS) ? act_in : csp_pkg::NUM_INPUTS - 1;
    endfunction

    function automatic void drop_tracking();
        halves     = '0;
        floor_ok   = 1'b0;
        floor_wait = 1'b0;
        at_sync    = 1'b0;
    endfunction

    // quarter-step move of the active threshold toward the floor/black midpoint
    function automatic bit track_level(input logic [11:0] low, input logic [11:0] black);
        logic [11:0] amp, mid;
        int          slot;
        if (black <= low) return 1'b0;
        amp = black - low;
        if (amp < amp_lo || amp > amp_hi) return 1'b0;
        mid = low + amp / 2;
        if (mid < mid_lo || mid > mid_hi) return 1'b0;
        slot = thr_slot();
        slice_thr[slot] = 12'((3 * int'(slice_thr[slot]) + int'(mid) + 2) / 4);
        return 1'b1;
    endfunction

    function automatic csp_pkg::csp_res_t parse_pulse(input logic op, input logic [15:0] ticks,
                                                      input logic adc_ok,
                                                      input logic [11:0] adc,
                                                      input logic sel);
        csp_pkg::csp_res_t r;
        r = '0;
        r.pulse_class = csp_pkg::CLS_NONE;
        if (op == csp_pkg::OP_RESTART) begin
            if (int'(sel) < csp_pkg::NUM_INPUTS) begin
                act_in    = int'(sel);
                line_cnt  = '0;
                synced    = 1'b0;
                drop_tracking();
                discard_q = 1'b1;
                field_q   = 1'b0;
                lock_q    = 1'b0;
            end
        end else if (discard_q) begin
            discard_q = 1'b0;
        end else if (ticks > csp_pkg::FULL_LO && ticks < csp_pkg::FULL_HI) begin
            r.pulse_class = csp_pkg::CLS_FULL;
            if (halves >= csp_pkg::HALF_FIELD_MIN) begin
                line_cnt      = '0;
                synced        = 1'b1;
                lock_q        = 1'b1;
                r.field_start = 1'b1;
            end
            drop_tracking();
            if (synced && line_cnt <= last_line) begin
                if (line_cnt != csp_pkg::LINE_CAP) line_cnt = line_cnt + 9'd1;
                r.line_strobe = (line_cnt <= last_line);
                field_q       = 1'b1;
            end
        end else if (ticks > csp_pkg::HALF_LO && ticks < csp_pkg::HALF_HI) begin
            r.pulse_class = csp_pkg::CLS_HALF;
            if (halves != csp_pkg::HALF_SAT) halves = halves + 8'd1;
            if (halves == csp_pkg::HALF_FLOOR && floor_wait) begin
                floor_ok = adc_ok;
                if (adc_ok) floor_code = adc;
                at_sync    = 1'b0;
                floor_wait = 1'b0;
            end
            if (halves == csp_pkg::HALF_BLACK && floor_ok) begin
                if (adc_ok) r.threshold_updated = track_level(floor_code, adc);
                floor_ok = 1'b0;
            end
            field_q = 1'b0;
        end else if (ticks > csp_pkg::BROAD_LO && ticks < csp_pkg::BROAD_HI) begin
            r.pulse_class = csp_pkg::CLS_BROAD;
            if (halves >= csp_pkg::HALF_FIELD_MIN) begin
                halves     = csp_pkg::HALF_FIELD_MIN;
                floor_ok   = 1'b0;
                floor_wait = 1'b1;
                at_sync    = 1'b1;
            end
        end else if (ticks > csp_pkg::EDGE_LO && ticks < csp_pkg::EDGE_HI) begin
            r.pulse_class = csp_pkg::CLS_EDGE;
        end else begin
            r.pulse_class = csp_pkg::CLS_OTHER;
            drop_tracking();
        end
        r.line_number    = line_cnt;
        r.locked         = lock_q;
        r.field_active   = field_q;
        r.sample_at_sync = at_sync;
        r.threshold      = slice_thr[thr_slot()];
        return r;
    endfunction

    function automatic string show(input csp_pkg::csp_res_t r);
        return {$sformatf("cls %0d strobe %0b line %0d start %0b lock %0b field %0b",
                          r.pulse_class, r.line_strobe, r.line_number, r.field_start,
                          r.locked, r.field_active),
                $sformatf(" sync %0b thr %0d upd %0b",
                          r.sample_at_sync, r.threshold, r.threshold_updated)};
    endfunction

    always @(posedge aclk) begin
        csp_pkg::csp_res_t want, got;
        if (!aresetn) begin
            amp_lo     = csp_pkg::AMP_MIN_RESET;
            amp_hi     = csp_pkg::AMP_MAX_RESET;
            mid_lo     = csp_pkg::THR_MIN_RESET;
            mid_hi     = csp_pkg::THR_MAX_RESET;
            last_line  = csp_pkg::MAX_LINE_RESET;
            halves     = '0;
            line_cnt   = '0;
            floor_code = '0;
            act_in     = int'(csp_pkg::ACTIVE_RESET);
            synced     = 1'b0;
            lock_q     = 1'b0;
            discard_q  = 1'b1;
            floor_ok   = 1'b0;
            floor_wait = 1'b0;
            field_q    = 1'b0;
            at_sync    = 1'b0;
            for (int i = 0; i < csp_pkg::NUM_INPUTS; i++) slice_thr[i] = csp_pkg::THR_RESET;
            line_results.delete();
            bad_results = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    csp_pkg::REG_AMP_MIN:  amp_lo    = cfg_wdata;
                    csp_pkg::REG_AMP_MAX:  amp_hi    = cfg_wdata;
                    csp_pkg::REG_THR_MIN:  mid_lo    = cfg_wdata;
                    csp_pkg::REG_THR_MAX:  mid_hi    = cfg_wdata;
                    csp_pkg::REG_MAX_LINE: last_line = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                line_results.push_back(parse_pulse(s_op, s_interval_ticks, s_adc_valid,
                                                   s_adc_sample, s_input_sel));
            if (m_valid && m_ready) begin
                got = csp_pkg::csp_res_t'({m_pulse_class, m_line_strobe, m_line_number,
                                           m_field_start, m_locked, m_field_active,
                                           m_sample_at_sync, m_threshold,
                                           m_threshold_updated});
                if (line_results.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10) $display("unrequested result: %s", show(got));
                end else begin
                    want = line_results.pop_front();
                    if (got !== want) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
        end
        results_owed = line_results.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    // cycles with no request or result moving before the run is called hung
    localparam int QUIET_LIMIT = 3000;
    // long receiver hold-off, so the queue fills and s_ready drops
    localparam int HOLD_LEN    = 200;
    // front register, queue and result register, plus margin
    localparam int DRAIN_LAT   = 8;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [11:0] cfg_wdata = '0;

    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_op             = 1'b0;
    logic [15:0] s_interval_ticks = '0;
    logic        s_adc_valid      = 1'b0;
    logic [11:0] s_adc_sample     = '0;
    logic        s_input_sel      = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_pulse_class;
    logic        m_line_strobe;
    logic [8:0]  m_line_number;
    logic        m_field_start;
    logic        m_locked;
    logic        m_field_active;
    logic        m_sample_at_sync;
    logic [11:0] m_threshold;
    logic        m_threshold_updated;

    int bad_results;
    int results_owed;

    int src_idle  = 0;     // percent of cycles the sender sits idle
    int snk_stall = 0;     // percent of cycles the receiver stalls
    int req_sent  = 0;
    int quiet     = 0;
    int hold_left = 0;
    bit hold_ask  = 1'b0;  // toggled by the stimulus to ask for a hold-off
    bit hold_seen = 1'b0;

    // exact window bounds, all of which fall outside their window
    logic [15:0] window_edges [8] = '{csp_pkg::FULL_LO, csp_pkg::FULL_HI,
                                      csp_pkg::HALF_LO, csp_pkg::HALF_HI,
                                      csp_pkg::BROAD_LO, csp_pkg::BROAD_HI,
                                      csp_pkg::EDGE_LO, csp_pkg::EDGE_HI};

    composite_sync_pulse_parser_core dut (.*);

    csp_line_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off counted here when asked
    always @(negedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // Watchdog: nothing accepted on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // One request: optional idle gap first, then hold valid until taken.
    // Entered and left at a falling edge.
    task automatic send_req(input csp_pkg::op_t op, input logic [15:0] ticks,
                            input logic adc_ok, input logic [11:0] adc, input logic sel);
        if ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_interval_ticks <= ticks;
        s_adc_valid      <= adc_ok;
        s_adc_sample     <= adc;
        s_input_sel      <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        req_sent++;
        @(negedge aclk);
    endtask

    // capture with random ADC side fields
    task automatic send_pulse(input logic [15:0] ticks);
        send_req(csp_pkg::OP_CAPTURE, ticks, 1'($urandom), 12'($urandom), 1'($urandom));
    endtask

    task automatic send_restart();
        send_req(csp_pkg::OP_RESTART, 16'($urandom), 1'($urandom), 12'($urandom),
                 1'($urandom));
    endtask

    // strictly inside an exclusive window
    function automatic logic [15:0] ticks_in(input logic [15:0] lo, input logic [15:0] hi);
        return 16'($urandom_range(int'(hi) - 1, int'(lo) + 1));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [11:0] a_lo, input logic [11:0] a_hi,
                                input logic [11:0] t_lo, input logic [11:0] t_hi,
                                input logic [8:0] last);
        write_reg(csp_pkg::REG_AMP_MIN, a_lo);
        write_reg(csp_pkg::REG_AMP_MAX, a_hi);
        write_reg(csp_pkg::REG_THR_MIN, t_lo);
        write_reg(csp_pkg::REG_THR_MAX, t_hi);
        write_reg(csp_pkg::REG_MAX_LINE, 12'(last));
        cfg_wr_en <= 1'b0;
    endtask

    // Sender stops until every expected result is back, then lets the pipe drain
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_LAT) @(negedge aclk);
    endtask

    // One vertical interval with random content: half lines, broad pulses,
    // half lines carrying the floor sample (fifth) and black sample (eleventh),
    // then a run of full lines. Sometimes preceded by a restart.
    task automatic run_frame();
        logic [11:0] floor_lvl, black_lvl;
        int          pre, broads, post, lines;
        floor_lvl = 12'($urandom_range(600));
        black_lvl = floor_lvl + 12'($urandom_range(900, 40));
        if ($urandom_range(7) == 0) begin
            floor_lvl = 12'($urandom);
            black_lvl = 12'($urandom);
        end
        pre    = $urandom_range(6, 2);
        broads = $urandom_range(5, 0);
        post   = $urandom_range(12, 3);
        lines  = ($urandom_range(5) == 0) ? $urandom_range(60, 10) : $urandom_range(9, 1);
        if ($urandom_range(4) == 0) begin
            send_restart();
            send_pulse(16'($urandom));      // thrown away by the block
        end
        repeat (pre) send_pulse(ticks_in(csp_pkg::HALF_LO, csp_pkg::HALF_HI));
        repeat (broads) send_pulse(ticks_in(csp_pkg::BROAD_LO, csp_pkg::BROAD_HI));
        for (int i = 1; i <= post; i++) begin
            if (i == 1 || i == 7)
                send_req(csp_pkg::OP_CAPTURE, ticks_in(csp_pkg::HALF_LO, csp_pkg::HALF_HI),
                         $urandom_range(9) != 0, (i == 1) ? floor_lvl : black_lvl,
                         1'($urandom));
            else
                send_pulse(ticks_in(csp_pkg::HALF_LO, csp_pkg::HALF_HI));
            if ($urandom_range(19) == 0)
                send_pulse(ticks_in(csp_pkg::EDGE_LO, csp_pkg::EDGE_HI));
        end
        repeat (lines) begin
            send_pulse(ticks_in(csp_pkg::FULL_LO, csp_pkg::FULL_HI));
            if ($urandom_range(29) == 0)
                send_pulse(ticks_in(csp_pkg::EDGE_LO, csp_pkg::EDGE_HI));
        end
    endtask

    // stray request: any interval, exact bounds, odd pulses or a restart
    task automatic run_noise();
        logic [15:0] t;
        case ($urandom_range(5))
            0:       t = 16'($urandom);
            1:       t = window_edges[$urandom_range(7)];
            2:       t = ticks_in(csp_pkg::EDGE_LO, csp_pkg::EDGE_HI);
            3:       t = ticks_in(csp_pkg::FULL_LO, csp_pkg::FULL_HI);
            4:       t = ticks_in(csp_pkg::HALF_LO, csp_pkg::HALF_HI);
            default: t = ticks_in(csp_pkg::BROAD_LO, csp_pkg::BROAD_HI);
        endcase
        if ($urandom_range(11) == 0) send_restart();
        else send_pulse(t);
    endtask

    task automatic run_phase(input int count, input int src, input int snk);
        int stop_at;
        stop_at   = req_sent + count;
        src_idle  <= src;
        snk_stall <= snk;
        while (req_sent < stop_at) begin
            if ($urandom_range(9) < 8) run_frame();
            else repeat ($urandom_range(6, 1)) run_noise();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: window bounds, discard after restart, one full
        // vertical interval with a threshold update, field start.
        send_req(csp_pkg::OP_RESTART, 16'hFFFF, 1'b1, 12'hFFF, 1'b0);
        send_pulse(16'hFFFF);               // discarded after restart
        send_pulse(16'd0);
        send_pulse(csp_pkg::EDGE_LO);
        send_pulse(csp_pkg::EDGE_LO + 16'd1);
        send_pulse(csp_pkg::EDGE_HI - 16'd1);
        send_pulse(csp_pkg::HALF_LO);
        send_pulse(csp_pkg::HALF_HI);
        send_pulse(csp_pkg::BROAD_LO);
        send_pulse(csp_pkg::BROAD_HI);
        send_pulse(csp_pkg::FULL_LO);
        send_pulse(csp_pkg::FULL_HI);
        send_pulse(csp_pkg::HALF_LO + 16'd1);
        send_pulse(csp_pkg::HALF_HI - 16'd1);
        send_pulse(16'd5500);
        send_pulse(16'd5500);
        send_pulse(csp_pkg::BROAD_LO + 16'd1);  // half count back to four, floor armed
        send_pulse(csp_pkg::BROAD_HI - 16'd1);
        send_req(csp_pkg::OP_CAPTURE, 16'd5500, 1'b1, 12'd100, 1'b0);     // sync floor
        repeat (5) send_pulse(16'd5500);
        send_req(csp_pkg::OP_CAPTURE, 16'd5500, 1'b1, 12'd600, 1'b1);     // black level
        send_pulse(csp_pkg::FULL_LO + 16'd1);   // starts a field
        send_pulse(csp_pkg::FULL_HI - 16'd1);
        send_req(csp_pkg::OP_RESTART, 16'd0, 1'b0, 12'd0, 1'b1);

        // Defaults, no idling; opens with a long receiver hold-off while
        // the sender keeps pushing
        settle();
        program_regs(csp_pkg::AMP_MIN_RESET, csp_pkg::AMP_MAX_RESET, csp_pkg::THR_MIN_RESET,
                     csp_pkg::THR_MAX_RESET, csp_pkg::MAX_LINE_RESET);
        hold_ask <= ~hold_ask;
        run_phase(220, 0, 0);

        // Widest acceptance, idle sender
        settle();
        program_regs(12'd0, 12'hFFF, 12'd0, 12'hFFF, 9'd511);
        run_phase(200, 58, 0);

        // Nothing acceptable, one-line field: lines past the end
        settle();
        program_regs(12'hFFF, 12'd0, 12'hFFF, 12'd0, 9'd1);
        run_phase(200, 0, 58);

        // Random moderate settings, both sides idle; a sender pause midway
        settle();
        program_regs(12'($urandom_range(200)), 12'($urandom_range(4095, 400)),
                     12'($urandom_range(200)), 12'($urandom_range(4095, 500)),
                     9'($urandom_range(40, 2)));
        run_phase(110, 35, 35);
        settle();
        run_phase(110, 35, 35);

        // Long run: half count saturates, then the line count climbs to its
        // ceiling and holds there
        settle();
        program_regs(csp_pkg::AMP_MIN_RESET, csp_pkg::AMP_MAX_RESET, csp_pkg::THR_MIN_RESET,
                     csp_pkg::THR_MAX_RESET, 9'd511);
        src_idle  <= 35;
        snk_stall <= 35;
        send_restart();
        send_pulse(16'($urandom));
        repeat (260) send_pulse(ticks_in(csp_pkg::HALF_LO, csp_pkg::HALF_HI));
        send_pulse(ticks_in(csp_pkg::BROAD_LO, csp_pkg::BROAD_HI));
        send_pulse(ticks_in(csp_pkg::FULL_LO, csp_pkg::FULL_HI));
        repeat (514) send_pulse(ticks_in(csp_pkg::FULL_LO, csp_pkg::FULL_HI));

        settle();
        if (bad_results == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
